// File: src/pft_pkg.sv
package pft_pkg;

  // result kinds
  localparam logic [1:0] KIND_FIRE   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // input actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;  // unused code, only done

  localparam int unsigned DVD_W = 32;
  localparam int unsigned DVS_W = 24;

  // one timer entry as stored in the table memory
  typedef struct packed {
    logic [7:0]  id;
    logic [23:0] period;
    logic        once;
    logic        level;
    logic        armed;
    logic [23:0] phase;
    logic [31:0] base;
  } entry_t;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // divider status
  typedef struct packed {
    logic             done;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_REJ,
    S_RD,
    S_CHK,
    S_ARM,
    S_FIRE,
    S_REFIRE,
    S_DONE
  } state_t;

endpackage

// File: src/pft_div.sv
// Restoring divider, one quotient bit a cycle; only the remainder is kept.
module pft_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pft_pkg::div_req_t req,
  output pft_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(pft_pkg::DVD_W + 1);

  logic [pft_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [pft_pkg::DVS_W:0]   rem_r, rem_nxt;
  logic [pft_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [pft_pkg::DVS_W:0]   trial;

  // one shift-and-subtract step
  always_comb begin
    trial    = {rem_r[pft_pkg::DVS_W-1:0], dvd_r[pft_pkg::DVD_W-1]};
    dvd_nxt  = {dvd_r[pft_pkg::DVD_W-2:0], 1'b0};
    rem_nxt  = (trial >= {1'b0, dvs_r}) ? trial - {1'b0, dvs_r} : trial;
    cnt_nxt  = cnt_r - CNT_W'(1);
    busy_nxt = busy_r && (cnt_r != CNT_W'(1));
    done_nxt = busy_r && (cnt_r == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(pft_pkg::DVD_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) cnt_r <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[pft_pkg::DVS_W-1:0];

endmodule

// File: src/pft_mem.sv
// Entry memory: one write port, one registered read port.
module pft_mem #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  pft_pkg::entry_t     wr_data,
  input  logic [IW-1:0]       rd_addr,
  output pft_pkg::entry_t     rd_data
);

  pft_pkg::entry_t mem [SLOTS];
  pft_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/periodic_flag_timer_table.sv
// Channel | Ports                          | Contents
// in      | in_tvalid/in_tready/in_tdata   | tuser: action; tdata: id, period, flags, now
// out     | out_tvalid/out_tready/out_tdata| tuser: kind; tlast: last; tdata: id, level
// Sequencing: remove walks the entries until the id matches; tick walks every
//   entry, and each entry that arms or refires waits on the shared 32-step
//   divider.
// Reset: rst_n synchronous, clears the sequencer, walk index, entry count,
//   output valid and age order. Stalls: each result waits in one output
//   register; the walk pauses while it is full. No new item is taken until the done transfer is loaded.
module periodic_flag_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // trigger_id[7:0] period_ms[31:8] one_shot[32]
                                  // drive_high[33] now_ms[65:34], zero pad
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // fired_id[7:0] level[8], zero pad
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  pft_pkg::state_t state_r, state_nxt;

  // latched item
  logic [1:0]  act_r;
  logic [7:0]  id_r;
  logic [23:0] per_r;
  logic        once_r, lvl_r;
  logic [31:0] now_r;
  logic [31:0] t_r;

  // age order: ord_r[0] newest, live entries in [0,cnt), free slots behind
  logic [IW-1:0] ord_r [SLOTS];
  logic [CW-1:0] cnt_r, k_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_id_r;
  logic       out_lvl_r, out_last_r;

  pft_pkg::entry_t  rd_data, wr_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr, rd_addr;
  pft_pkg::div_req_t div_req;
  pft_pkg::div_rsp_t div_rsp;

  logic        accept, out_free, table_full;
  logic        id_match, fire;
  logic [31:0] t_calc;
  logic [32:0] due;

  // control outputs
  logic       do_rotate, do_drop, do_step, do_load;
  logic [1:0] ld_kind;
  logic [7:0] ld_id;
  logic       ld_lvl, ld_last;

  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = (cnt_r == CW'(SLOTS));
  assign rd_addr    = ord_r[k_r[IW-1:0]];

  // entry checks
  assign id_match = (rd_data.id == id_r);
  assign t_calc   = now_r - {8'd0, rd_data.phase};
  assign due      = {1'b0, rd_data.base} + {9'd0, rd_data.period};
  assign fire     = (now_r >= {8'd0, rd_data.phase}) && ({1'b0, t_calc} >= due);

  pft_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pft_pkg::S_IDLE: begin
        if (accept) begin
          priority case (in_tuser)
            pft_pkg::ACT_ADD:    state_nxt = pft_pkg::S_ADD;
            pft_pkg::ACT_REMOVE: state_nxt = pft_pkg::S_RD;
            pft_pkg::ACT_TICK:   state_nxt = pft_pkg::S_RD;
            default:             state_nxt = pft_pkg::S_DONE;
          endcase
        end
      end
      pft_pkg::S_ADD: begin
        if (per_r == 24'd0 || table_full) state_nxt = pft_pkg::S_REJ;
        else state_nxt = pft_pkg::S_DONE;
      end
      pft_pkg::S_REJ: begin
        if (out_free) state_nxt = pft_pkg::S_DONE;
      end
      pft_pkg::S_RD: begin
        if (k_r == cnt_r) state_nxt = pft_pkg::S_DONE;
        else state_nxt = pft_pkg::S_CHK;
      end
      pft_pkg::S_CHK: begin
        if (act_r == pft_pkg::ACT_REMOVE) begin
          state_nxt = id_match ? pft_pkg::S_DONE : pft_pkg::S_RD;
        end else if (!rd_data.armed) begin
          state_nxt = pft_pkg::S_ARM;
        end else if (fire) begin
          state_nxt = pft_pkg::S_FIRE;
        end else begin
          state_nxt = pft_pkg::S_RD;
        end
      end
      pft_pkg::S_ARM: begin
        if (div_rsp.done) state_nxt = pft_pkg::S_RD;
      end
      pft_pkg::S_FIRE: begin
        if (out_free) state_nxt = rd_data.once ? pft_pkg::S_RD : pft_pkg::S_REFIRE;
      end
      pft_pkg::S_REFIRE: begin
        if (div_rsp.done) state_nxt = pft_pkg::S_RD;
      end
      pft_pkg::S_DONE: begin
        if (out_free) state_nxt = pft_pkg::S_IDLE;
      end
      default: state_nxt = pft_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready        = (state_r == pft_pkg::S_IDLE);
    do_rotate        = 1'b0;
    do_drop          = 1'b0;
    do_step          = 1'b0;
    do_load          = 1'b0;
    ld_kind          = pft_pkg::KIND_DONE;
    ld_id            = 8'd0;
    ld_lvl           = 1'b0;
    ld_last          = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = rd_addr;
    wr_data          = rd_data;
    div_req.start    = 1'b0;
    div_req.dividend = now_r;
    div_req.divisor  = rd_data.period;
    unique case (state_r)
      pft_pkg::S_ADD: begin
        if (per_r != 24'd0 && !table_full) begin
          do_rotate      = 1'b1;
          wr_en          = 1'b1;
          wr_addr        = ord_r[SLOTS-1];
          wr_data.id     = id_r;
          wr_data.period = per_r;
          wr_data.once   = once_r;
          wr_data.level  = lvl_r;
          wr_data.armed  = 1'b0;
          wr_data.phase  = 24'd0;
          wr_data.base   = 32'd0;
        end
      end
      pft_pkg::S_REJ: begin
        do_load = out_free;
        ld_kind = pft_pkg::KIND_REJECT;
        ld_id   = id_r;
      end
      pft_pkg::S_CHK: begin
        if (act_r == pft_pkg::ACT_REMOVE) begin
          do_drop = id_match;
          do_step = !id_match;
        end else if (!rd_data.armed) begin
          div_req.start = 1'b1;
        end else begin
          do_step = !fire;
        end
      end
      pft_pkg::S_ARM: begin
        if (div_rsp.done) begin
          do_step       = 1'b1;
          wr_en         = 1'b1;
          wr_data.armed = 1'b1;
          wr_data.phase = div_rsp.rem;
          wr_data.base  = now_r - {8'd0, div_rsp.rem};
        end
      end
      pft_pkg::S_FIRE: begin
        do_load          = out_free;
        ld_kind          = pft_pkg::KIND_FIRE;
        ld_id            = rd_data.id;
        ld_lvl           = rd_data.level;
        do_drop          = out_free && rd_data.once;
        div_req.start    = out_free && !rd_data.once;
        div_req.dividend = t_r;
      end
      pft_pkg::S_REFIRE: begin
        if (div_rsp.done) begin
          do_step      = 1'b1;
          wr_en        = 1'b1;
          wr_data.base = t_r - {8'd0, div_rsp.rem};
        end
      end
      pft_pkg::S_DONE: begin
        do_load = out_free;
        ld_last = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pft_pkg::S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < SLOTS; j++) ord_r[j] <= IW'(j);
    end else begin
      state_r <= state_nxt;
      if (accept) k_r <= '0;
      else if (do_step) k_r <= k_r + CW'(1);
      if (do_rotate) begin
        cnt_r    <= cnt_r + CW'(1);
        ord_r[0] <= ord_r[SLOTS-1];
        for (int j = 1; j < SLOTS; j++) ord_r[j] <= ord_r[j-1];
      end else if (do_drop) begin
        // freed slot goes to the tail, younger order is kept
        cnt_r <= cnt_r - CW'(1);
        for (int j = 0; j < SLOTS - 1; j++) begin
          if (CW'(j) >= k_r) ord_r[j] <= ord_r[j+1];
        end
        ord_r[SLOTS-1] <= ord_r[k_r[IW-1:0]];
      end
      if (do_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_tuser;
      id_r   <= in_tdata[7:0];
      per_r  <= in_tdata[31:8];
      once_r <= in_tdata[32];
      lvl_r  <= in_tdata[33];
      now_r  <= in_tdata[65:34];
    end
    if (state_r == pft_pkg::S_CHK) t_r <= t_calc;
    if (do_load) begin
      out_kind_r <= ld_kind;
      out_id_r   <= ld_id;
      out_lvl_r  <= ld_lvl;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_lvl_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS)) else $error("entry count above table size");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= cnt_r) else $error("walk index past live entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("ready right after an accepted item");

  a_div_only_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == pft_pkg::S_ARM || state_r == pft_pkg::S_REFIRE))
    else $error("divider finished outside a wait state");

  a_no_load_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !do_load) else $error("result overwritten");

endmodule
